FILE: hw/rtl/plob_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plob_pkg
// Shared constants, codes and controller/datapath signal groups of the book.
// ----------------------------------------------------------------------------
package plob_pkg;

  localparam int ORDER_CAPACITY_DEF = 4096;
  localparam int LADDER_LEVELS_DEF  = 4096;

  localparam int PRICE_W    = 32;
  localparam int REF_W      = 64;
  localparam int SHARE_W    = 32;
  localparam int OP_W       = 2;
  localparam int ST_W       = 2;
  localparam int CNT_OUT_W  = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [OP_W-1:0] OP_ADD     = 2'd0;
  localparam logic [OP_W-1:0] OP_REDUCE  = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE  = 2'd2;
  localparam logic [OP_W-1:0] OP_REPLACE = 2'd3;

  localparam logic [ST_W-1:0] ST_APPLIED   = 2'd0;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [ST_W-1:0] ST_ZERO      = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_BAND_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TICK      = 2'd2;

  localparam logic [PRICE_W-1:0] BAND_LOW_RST  = 32'd0;
  localparam logic [PRICE_W-1:0] BAND_HIGH_RST = 32'd4095;
  localparam logic [PRICE_W-1:0] TICK_RST      = 32'd1;

  typedef struct packed {
    logic            load;
    logic            clear;
    logic            scan_start;
    logic            scan_key_new;
    logic            scan_step;
    logic            ent_store;
    logic            ent_rm;
    logic            div_start;
    logic            lad_rd;
    logic            lad_wr;
    logic            rs_init;
    logic            rs_rd;
    logic            rs_chk;
    logic            out_load;
    logic            set_status;
    logic [ST_W-1:0] status;
  } cmd_t;

  typedef struct packed {
    logic            clear_done;
    logic            scan_done;
    logic            found;
    logic            free_found;
    logic            zero_shares;
    logic            in_band;
    logic            div_busy;
    logic            lvl_ok;
    logic            ladd;
    logic            rs_need;
    logic            rs_abort;
    logic            rs_end;
    logic            out_free;
    logic [OP_W-1:0] op;
  } sts_t;

endpackage

FILE: hw/rtl/plob_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plob_div
// Restoring divider, one quotient bit per cycle, for the ladder level index.
// ----------------------------------------------------------------------------
module plob_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [plob_pkg::PRICE_W-1:0]  dividend,
  input  logic [plob_pkg::PRICE_W-1:0]  divisor,
  output logic                          busy,
  output logic [plob_pkg::PRICE_W-1:0]  quot
);

  localparam int W  = plob_pkg::PRICE_W;
  localparam int CW = $clog2(W + 1);

  logic [W:0]    rem;
  logic [W-1:0]  dvs;
  logic [CW-1:0] cnt;
  logic [W:0]    rem_sh;
  logic          fits;

  assign rem_sh = {rem[W-1:0], quot[W-1]};
  assign fits   = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(W);
      rem  <= '0;
      quot <= dividend;
      dvs  <= divisor;
    end else if (busy) begin
      rem  <= fits ? rem_sh - {1'b0, dvs} : rem_sh;
      quot <= {quot[W-2:0], fits};
      cnt  <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

FILE: hw/rtl/plob_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plob_datapath
// Order table, share ladders, best prices, config and output word register.
// ----------------------------------------------------------------------------
module plob_datapath #(
  parameter int CAP    = plob_pkg::ORDER_CAPACITY_DEF,
  parameter int LEVELS = plob_pkg::LADDER_LEVELS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  plob_pkg::cmd_t                   cmd,
  output plob_pkg::sts_t                   sts,
  input  logic                             cfg_write,
  input  logic [plob_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [plob_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [plob_pkg::OP_W-1:0]        operation,
  input  logic [plob_pkg::REF_W-1:0]       order_ref,
  input  logic [plob_pkg::REF_W-1:0]       new_order_ref,
  input  logic                             buy_or_sell,
  input  logic [plob_pkg::PRICE_W-1:0]     limit_price,
  input  logic [plob_pkg::SHARE_W-1:0]     share_count,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [plob_pkg::PRICE_W-1:0]     top_bid,
  output logic                             top_bid_present,
  output logic [plob_pkg::PRICE_W-1:0]     top_ask,
  output logic                             top_ask_present,
  output logic [plob_pkg::CNT_OUT_W-1:0]   resting_count,
  output logic [plob_pkg::ST_W-1:0]        event_status
);

  localparam int PW_ = plob_pkg::PRICE_W;
  localparam int SW  = plob_pkg::SHARE_W;
  localparam int RW  = plob_pkg::REF_W;
  localparam int CW  = $clog2(CAP);
  localparam int LW  = $clog2(LEVELS);
  localparam int MAXD = (CAP > LEVELS) ? CAP : LEVELS;
  localparam int PTW = $clog2(MAXD + 1);
  localparam int NW  = $clog2(CAP + 1);
  localparam int RSW = PW_ + LW + 1;

  // config
  logic [PW_-1:0] band_low, band_high, tick;
  logic [PW_-1:0] tick_eff;

  // latched item
  logic [plob_pkg::OP_W-1:0] op;
  logic [RW-1:0]  in_ref, in_new_ref, skey;
  logic           sside;
  logic [PW_-1:0] in_price;
  logic [SW-1:0]  in_shares;
  logic [plob_pkg::ST_W-1:0] status;

  // table
  logic [RW-1:0]  keys   [CAP];
  logic [PW_-1:0] prices [CAP];
  logic [SW-1:0]  shares [CAP];
  logic           sides  [CAP];
  logic           live   [CAP];
  logic [RW-1:0]  key_q;
  logic [PW_-1:0] price_q;
  logic [SW-1:0]  shares_q;
  logic           side_q, live_q;

  logic [PTW-1:0] ptr;
  logic [CW-1:0]  rd_idx;
  logic           rd_v;
  logic           found, free_found;
  logic [CW-1:0]  fidx, free_idx, widx;
  logic [PW_-1:0] eprice;
  logic [SW-1:0]  eshares;
  logic           eside;
  logic [NW-1:0]  count;

  logic [SW-1:0]  gone, remain;
  logic           erase;

  // ladders
  logic [SW-1:0]  bid_lad [LEVELS];
  logic [SW-1:0]  ask_lad [LEVELS];
  logic [SW-1:0]  bid_q, ask_q, lad_cur, lad_new;
  logic [SW:0]    lad_sum;
  logic           lside, ladd;
  logic [PW_-1:0] lprice;
  logic [SW-1:0]  lamt;
  logic [LW-1:0]  lvl, ra;
  logic [LW:0]    rs_i;
  logic [RSW-1:0] rs_p;

  logic [PW_-1:0] bid_best, ask_best;
  logic           bid_live, ask_live;

  logic           div_busy;
  logic [PW_-1:0] quot;

  assign tick_eff = (tick == '0) ? PW_'(1) : tick;

  always_ff @(posedge clk) begin
    if (rst) begin
      band_low  <= plob_pkg::BAND_LOW_RST;
      band_high <= plob_pkg::BAND_HIGH_RST;
      tick      <= plob_pkg::TICK_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        plob_pkg::CFG_BAND_LOW:  band_low  <= cfg_data;
        plob_pkg::CFG_BAND_HIGH: band_high <= cfg_data;
        plob_pkg::CFG_TICK:      tick      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op         <= operation;
      in_ref     <= order_ref;
      in_new_ref <= new_order_ref;
      in_price   <= limit_price;
      in_shares  <= share_count;
    end
    if (cmd.load) begin
      sside <= buy_or_sell;
    end else if (cmd.ent_rm) begin
      sside <= eside;
    end
    if (cmd.scan_start) begin
      skey <= cmd.scan_key_new ? in_new_ref : in_ref;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      status <= plob_pkg::ST_APPLIED;
    end else if (cmd.load) begin
      status <= plob_pkg::ST_APPLIED;
    end else if (cmd.set_status) begin
      status <= cmd.status;
    end
  end

  // shared pointer: clearing pass after reset, then table scan
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr        <= '0;
      rd_v       <= 1'b0;
      found      <= 1'b0;
      free_found <= 1'b0;
    end else if (cmd.clear) begin
      ptr <= ptr + 1'b1;
    end else if (cmd.scan_start) begin
      ptr        <= '0;
      rd_v       <= 1'b0;
      found      <= 1'b0;
      free_found <= 1'b0;
    end else if (cmd.scan_step) begin
      rd_v   <= (ptr < PTW'(CAP)) && !found;
      rd_idx <= ptr[CW-1:0];
      if (ptr < PTW'(CAP) && !found) begin
        ptr <= ptr + 1'b1;
      end
      if (rd_v && !found) begin
        if (live_q && key_q == skey) begin
          found   <= 1'b1;
          fidx    <= rd_idx;
          eprice  <= price_q;
          eshares <= shares_q;
          eside   <= side_q;
        end else if (!live_q && !free_found) begin
          free_found <= 1'b1;
          free_idx   <= rd_idx;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step) begin
      key_q    <= keys[ptr[CW-1:0]];
      price_q  <= prices[ptr[CW-1:0]];
      shares_q <= shares[ptr[CW-1:0]];
      side_q   <= sides[ptr[CW-1:0]];
      live_q   <= live[ptr[CW-1:0]];
    end
  end

  assign gone   = (in_shares < eshares) ? in_shares : eshares;
  assign remain = eshares - gone;
  assign erase  = (op != plob_pkg::OP_REDUCE) || (remain == '0);
  assign widx   = found ? fidx : free_idx;

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      if (ptr < PTW'(CAP)) begin
        live[ptr[CW-1:0]] <= 1'b0;
      end
    end else if (cmd.ent_store) begin
      live[widx]   <= 1'b1;
      keys[widx]   <= skey;
      prices[widx] <= in_price;
      shares[widx] <= in_shares;
      sides[widx]  <= sside;
    end else if (cmd.ent_rm) begin
      live[fidx]   <= !erase;
      shares[fidx] <= remain;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.ent_store && !found) begin
      count <= count + 1'b1;
    end else if (cmd.ent_rm && erase) begin
      count <= count - 1'b1;
    end
  end

  // ladder operand set up with each table write
  always_ff @(posedge clk) begin
    if (rst) begin
      ladd <= 1'b0;
    end else if (cmd.ent_store) begin
      ladd   <= 1'b1;
      lside  <= sside;
      lprice <= in_price;
      lamt   <= in_shares;
    end else if (cmd.ent_rm) begin
      ladd   <= 1'b0;
      lside  <= eside;
      lprice <= eprice;
      lamt   <= (op == plob_pkg::OP_REDUCE) ? gone : eshares;
    end
  end

  plob_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (lprice - band_low),
    .divisor  (tick_eff),
    .busy     (div_busy),
    .quot     (quot)
  );

  assign ra = cmd.rs_rd ? rs_i[LW-1:0] : quot[LW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.lad_rd || cmd.rs_rd) begin
      bid_q <= bid_lad[ra];
      ask_q <= ask_lad[ra];
    end
    if (cmd.lad_rd) begin
      lvl <= quot[LW-1:0];
    end
  end

  assign lad_cur = lside ? ask_q : bid_q;
  assign lad_sum = {1'b0, lad_cur} + {1'b0, lamt};
  always_comb begin
    if (ladd) begin
      lad_new = lad_sum[SW] ? '1 : lad_sum[SW-1:0];
    end else begin
      lad_new = (lamt >= lad_cur) ? '0 : lad_cur - lamt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      if (ptr < PTW'(LEVELS)) begin
        bid_lad[ptr[LW-1:0]] <= '0;
        ask_lad[ptr[LW-1:0]] <= '0;
      end
    end else if (cmd.lad_wr) begin
      if (lside) begin
        ask_lad[lvl] <= lad_new;
      end else begin
        bid_lad[lvl] <= lad_new;
      end
    end
  end

  // best prices and rescan walk
  always_ff @(posedge clk) begin
    if (rst) begin
      bid_best <= '0;
      bid_live <= 1'b0;
      ask_best <= '0;
      ask_live <= 1'b0;
    end else if (cmd.lad_wr && ladd) begin
      if (!lside) begin
        if (!bid_live || lprice > bid_best) begin
          bid_best <= lprice;
          bid_live <= 1'b1;
        end
      end else if (!ask_live || lprice < ask_best) begin
        ask_best <= lprice;
        ask_live <= 1'b1;
      end
    end else if (cmd.rs_rd && sts.rs_abort) begin
      ask_best <= '0;
      ask_live <= 1'b0;
    end else if (cmd.rs_chk) begin
      if (!lside) begin
        if (bid_q != '0) begin
          bid_best <= rs_p[PW_-1:0];
        end else if (rs_i == '0) begin
          bid_best <= '0;
          bid_live <= 1'b0;
        end
      end else if (ask_q != '0) begin
        ask_best <= rs_p[PW_-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rs_init) begin
      rs_i <= {1'b0, lvl};
      rs_p <= RSW'(lside ? ask_best : bid_best);
    end else if (cmd.rs_chk && !sts.rs_end) begin
      if (lside) begin
        rs_i <= rs_i + 1'b1;
        rs_p <= rs_p + RSW'(tick_eff);
      end else begin
        rs_i <= rs_i - 1'b1;
        rs_p <= rs_p - RSW'(tick_eff);
      end
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      top_bid         <= bid_live ? bid_best : '0;
      top_bid_present <= bid_live;
      top_ask         <= ask_live ? ask_best : '0;
      top_ask_present <= ask_live;
      resting_count   <= plob_pkg::CNT_OUT_W'(count);
      event_status    <= status;
    end
  end

  always_comb begin
    sts.clear_done  = ptr == PTW'(MAXD);
    sts.scan_done   = found || (ptr == PTW'(CAP) && !rd_v);
    sts.found       = found;
    sts.free_found  = free_found;
    sts.zero_shares = in_shares == '0;
    sts.in_band     = (lprice >= band_low) && (lprice <= band_high);
    sts.div_busy    = div_busy;
    sts.lvl_ok      = quot < PW_'(LEVELS);
    sts.ladd        = ladd;
    sts.rs_need     = !ladd && (lad_new == '0) &&
                      (lside ? (ask_live && lprice == ask_best)
                             : (bid_live && lprice == bid_best));
    sts.rs_abort    = lside && ((rs_i >= (LW+1)'(LEVELS)) ||
                                (rs_p > RSW'(band_high)));
    sts.rs_end      = lside ? (ask_q != '0) : ((bid_q != '0) || (rs_i == '0));
    sts.out_free    = !out_valid || !out_stall;
    sts.op          = op;
  end

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= NW'(CAP))
    else $error("live order count above capacity");
  a_bid_clear: assert property (@(posedge clk) disable iff (rst)
    !bid_live |-> bid_best == '0)
    else $error("bid price held without a bid");
  a_ask_clear: assert property (@(posedge clk) disable iff (rst)
    !ask_live |-> ask_best == '0)
    else $error("ask price held without an ask");
  a_store_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.ent_store |-> (found || free_found))
    else $error("order stored without a slot");

endmodule

FILE: hw/rtl/plob_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plob_ctrl
// Sequencer for one feed event: scan, table write, ladder update, rescan.
// ----------------------------------------------------------------------------
module plob_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           idle,
  input  plob_pkg::sts_t sts,
  output plob_pkg::cmd_t cmd
);

  localparam logic [3:0] S_CLR    = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_START  = 4'd2;
  localparam logic [3:0] S_SCAN   = 4'd3;
  localparam logic [3:0] S_DECIDE = 4'd4;
  localparam logic [3:0] S_LV     = 4'd5;
  localparam logic [3:0] S_DIVW   = 4'd6;
  localparam logic [3:0] S_LRD    = 4'd7;
  localparam logic [3:0] S_LWR    = 4'd8;
  localparam logic [3:0] S_RSI    = 4'd9;
  localparam logic [3:0] S_RSR    = 4'd10;
  localparam logic [3:0] S_RSC    = 4'd11;
  localparam logic [3:0] S_POST   = 4'd12;
  localparam logic [3:0] S_OUT    = 4'd13;

  logic [3:0] state, state_next;
  logic       scan2, scan2_next;

  assign idle = state == S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      scan2 <= 1'b0;
    end else begin
      state <= state_next;
      scan2 <= scan2_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    scan2_next = scan2;
    case (state)
      S_CLR: begin
        if (sts.clear_done) begin
          state_next = S_IDLE;
        end else begin
          cmd.clear = 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          scan2_next = 1'b0;
          state_next = S_START;
        end
      end
      S_START: begin
        if (sts.op == plob_pkg::OP_ADD && sts.zero_shares) begin
          cmd.set_status = 1'b1;
          cmd.status     = plob_pkg::ST_ZERO;
          state_next     = S_OUT;
        end else begin
          cmd.scan_start = 1'b1;
          state_next     = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (scan2 || sts.op == plob_pkg::OP_ADD) begin
          if (!sts.found && !sts.free_found) begin
            cmd.set_status = 1'b1;
            cmd.status     = plob_pkg::ST_FULL;
            state_next     = S_OUT;
          end else begin
            cmd.ent_store = 1'b1;
            state_next    = S_LV;
          end
        end else if (!sts.found) begin
          cmd.set_status = 1'b1;
          cmd.status     = plob_pkg::ST_NOT_FOUND;
          state_next     = S_OUT;
        end else begin
          cmd.ent_rm = 1'b1;
          state_next = S_LV;
        end
      end
      S_LV: begin
        if (sts.in_band) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIVW;
        end else begin
          state_next = S_POST;
        end
      end
      S_DIVW: begin
        if (!sts.div_busy) begin
          state_next = sts.lvl_ok ? S_LRD : S_POST;
        end
      end
      S_LRD: begin
        cmd.lad_rd = 1'b1;
        state_next = S_LWR;
      end
      S_LWR: begin
        cmd.lad_wr = 1'b1;
        state_next = sts.rs_need ? S_RSI : S_POST;
      end
      S_RSI: begin
        cmd.rs_init = 1'b1;
        state_next  = S_RSR;
      end
      S_RSR: begin
        cmd.rs_rd  = 1'b1;
        state_next = sts.rs_abort ? S_POST : S_RSC;
      end
      S_RSC: begin
        cmd.rs_chk = 1'b1;
        state_next = sts.rs_end ? S_POST : S_RSR;
      end
      S_POST: begin
        // a replace goes on to store the new order after the removal, unless its share count is zero
        if (!sts.ladd && !scan2 && sts.op == plob_pkg::OP_REPLACE) begin
          if (sts.zero_shares) begin
            cmd.set_status = 1'b1;
            cmd.status     = plob_pkg::ST_ZERO;
            state_next     = S_OUT;
          end else begin
            cmd.scan_start   = 1'b1;
            cmd.scan_key_new = 1'b1;
            scan2_next       = 1'b1;
            state_next       = S_SCAN;
          end
        end else begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: hw/rtl/price_level_order_book.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// price_level_order_book
// Level-2 book from decoded feed events: order table, bid and ask ladders,
// best prices with rescan when the touch level empties.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  in        in_valid / in_stall    operation, order_ref, new_order_ref,
//                                   buy_or_sell, limit_price, share_count
//  out       out_valid / out_stall  top_bid(_present), top_ask(_present),
//                                   resting_count, event_status
//  cfg       cfg_write              cfg_index, cfg_data
//
//  one event at a time; each takes a table scan (one entry per cycle through the
//  table memories, twice for a replace that stores its new order), the level
//  divider and ladder read-modify-write, and a walk over the levels when the
//  best level empties. after reset a clearing pass over the table and ladder
//  addresses clears live flags and ladders; no event is taken during it.
//  the finished word sits in the output register, held while out_stall is high.
// ----------------------------------------------------------------------------
module price_level_order_book #(
  parameter int ORDER_CAPACITY = plob_pkg::ORDER_CAPACITY_DEF,
  parameter int LADDER_LEVELS  = plob_pkg::LADDER_LEVELS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [plob_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [plob_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [plob_pkg::OP_W-1:0]        operation,
  input  logic [plob_pkg::REF_W-1:0]       order_ref,
  input  logic [plob_pkg::REF_W-1:0]       new_order_ref,
  input  logic                             buy_or_sell,
  input  logic [plob_pkg::PRICE_W-1:0]     limit_price,
  input  logic [plob_pkg::SHARE_W-1:0]     share_count,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [plob_pkg::PRICE_W-1:0]     top_bid,
  output logic                             top_bid_present,
  output logic [plob_pkg::PRICE_W-1:0]     top_ask,
  output logic                             top_ask_present,
  output logic [plob_pkg::CNT_OUT_W-1:0]   resting_count,
  output logic [plob_pkg::ST_W-1:0]        event_status
);

  plob_pkg::cmd_t cmd;
  plob_pkg::sts_t sts;
  logic           idle;

  assign in_stall = !idle;

  plob_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .idle     (idle),
    .sts      (sts),
    .cmd      (cmd)
  );

  plob_datapath #(
    .CAP    (ORDER_CAPACITY),
    .LEVELS (LADDER_LEVELS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .operation       (operation),
    .order_ref       (order_ref),
    .new_order_ref   (new_order_ref),
    .buy_or_sell     (buy_or_sell),
    .limit_price     (limit_price),
    .share_count     (share_count),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .top_bid         (top_bid),
    .top_bid_present (top_bid_present),
    .top_ask         (top_ask),
    .top_ask_present (top_ask_present),
    .resting_count   (resting_count),
    .event_status    (event_status)
  );

endmodule
